[rtl/core/forth_data_stack_alu_defines.svh]
// assertion macros for the forth data stack checker
// expects clk and rst in the scope where a macro is used
`ifndef FORTH_DATA_STACK_ALU_DEFINES_SVH
`define FORTH_DATA_STACK_ALU_DEFINES_SVH

// same-cycle implication
`define FDSA_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdsa check failed");

// next-cycle implication
`define FDSA_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdsa check failed");

`endif

[rtl/core/fdsa_pkg.sv]
// types, codes and operation tables for the forth data stack with alu
// no dependencies
package fdsa_pkg;

  localparam int DATA_W              = 32;
  localparam int OP_W                = 5;
  localparam int STATUS_W            = 2;
  localparam int DEPTH_W             = 9;
  localparam int LIMIT_W             = 9;
  localparam int DEFAULT_STACK_DEPTH = 256;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 5'd0,
    OP_POP    = 5'd1,
    OP_PEEK   = 5'd2,
    OP_DUP    = 5'd3,
    OP_SWAP   = 5'd4,
    OP_ADD    = 5'd5,
    OP_SUB    = 5'd6,
    OP_MUL    = 5'd7,
    OP_DIV    = 5'd8,
    OP_DIVMOD = 5'd9,
    OP_MOD    = 5'd10,
    OP_OVER   = 5'd11,
    OP_ROT    = 5'd12,
    OP_DROP   = 5'd13,
    OP_2SWAP  = 5'd14,
    OP_2DUP   = 5'd15,
    OP_2OVER  = 5'd16,
    OP_2DROP  = 5'd17,
    OP_LT     = 5'd18,
    OP_GT     = 5'd19,
    OP_EQ     = 5'd20,
    OP_NE     = 5'd21,
    OP_ZLT    = 5'd22,
    OP_ZGT    = 5'd23,
    OP_ZEQ    = 5'd24
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_UNDER = 2'd1,
    STS_OVER  = 2'd2,
    STS_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
    logic [DEPTH_W-1:0]       depth;
  } out_item_t;

  // entries an operation needs on the stack
  function automatic logic [2:0] need_of(input op_t op);
    logic [2:0] n;
    case (op) inside
      OP_PUSH:                                   n = 3'd0;
      OP_POP, OP_PEEK, OP_DUP, OP_DROP,
      OP_ZLT, OP_ZGT, OP_ZEQ:                    n = 3'd1;
      OP_ROT:                                    n = 3'd3;
      OP_2SWAP, OP_2OVER:                        n = 3'd4;
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVMOD, OP_MOD,
      OP_OVER, OP_2DUP, OP_2DROP, OP_LT, OP_GT, OP_EQ, OP_NE: n = 3'd2;
      default:                                   n = 3'd0;
    endcase
    return n;
  endfunction

  // change of depth an operation makes
  function automatic logic signed [2:0] grow_of(input op_t op);
    logic signed [2:0] g;
    case (op) inside
      OP_PUSH, OP_DUP, OP_OVER:                  g = 3'sd1;
      OP_2DUP, OP_2OVER:                         g = 3'sd2;
      OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DROP,
      OP_LT, OP_GT, OP_EQ, OP_NE:                g = -3'sd1;
      OP_2DROP:                                  g = -3'sd2;
      default:                                   g = 3'sd0;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/forth_data_stack_alu.sv]
// Forth data stack with an integer alu. An item is taken in ST_IDLE, then the top
// min(depth,4) entries are read from the stack memory one a cycle, each through the
// registered read port, the operation runs in ST_EXEC, the changed entries (0 to 4)
// are written back one a cycle, and the result is loaded into the output in ST_DONE.
// Divide, mod and /mod with a nonzero divisor pass through ST_DIV, a one-bit-a-cycle
// restoring divider, and ST_FIN before the write-back. The memory has one read port
// and one write port, used in separate states. No clearing pass after reset.
module forth_data_stack_alu
  import fdsa_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 2;

  state_t state, state_next;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [LIMIT_W-1:0] limit;
  logic [CW-1:0]      count, cnt_new;
  op_t                op;
  logic [DATA_W-1:0]  opnd;
  status_t            sts;
  logic [DATA_W-1:0]  win [4];
  logic [DATA_W-1:0]  nw [4];
  logic [2:0]         wcnt, nread, k, pidx;
  logic               pend;
  logic [DATA_W-1:0]  rem;
  logic [DATA_W-1:0]  quo, dvs;
  logic [$clog2(DATA_W)-1:0] itc;
  logic               q_neg, r_neg;

  // checks on the incoming item
  op_t               in_op;
  logic [2:0]        in_need;
  logic signed [2:0] in_grow;
  logic [EW-1:0]     n_e, cap_e, lim_e, dep_e;
  status_t           in_sts;

  always_comb begin
    in_op   = op_t'(in_item.operation);
    in_need = need_of(in_op);
    in_grow = grow_of(in_op);
    n_e     = EW'(count);
    lim_e   = EW'(limit);
    dep_e   = EW'(STACK_DEPTH);
    cap_e   = (lim_e < dep_e) ? lim_e : dep_e;
    if (n_e < EW'(in_need)) begin
      in_sts = STS_UNDER;
    end else if (in_grow > 3'sd0 && (n_e + EW'(unsigned'(in_grow))) > cap_e) begin
      in_sts = STS_OVER;
    end else begin
      in_sts = STS_OK;
    end
  end

  // operation datapath
  logic [DATA_W-1:0] ex_nw [4];
  logic [2:0]        ex_wcnt;
  logic [DATA_W-1:0] a, b, c, d;
  logic [DATA_W-1:0] prod;
  logic              is_div;
  logic signed [2:0] op_grow;
  logic [CW-1:0]     cnt_grow;

  always_comb begin
    a = win[0];
    b = win[1];
    c = win[2];
    d = win[3];
    prod = b * a;
    is_div = (op == OP_DIV) || (op == OP_DIVMOD) || (op == OP_MOD);
    op_grow = grow_of(op);
    cnt_grow = count + {{(CW-3){op_grow[2]}}, op_grow};
    ex_nw[0] = a;
    ex_nw[1] = '0;
    ex_nw[2] = '0;
    ex_nw[3] = '0;
    ex_wcnt  = 3'd0;
    case (op) inside
      OP_PUSH:  begin ex_nw[0] = opnd; ex_wcnt = 3'd1; end
      OP_DUP:   begin ex_nw[0] = a; ex_wcnt = 3'd1; end
      OP_SWAP:  begin ex_nw[0] = b; ex_nw[1] = a; ex_wcnt = 3'd2; end
      OP_ADD:   begin ex_nw[0] = b + a; ex_wcnt = 3'd1; end
      OP_SUB:   begin ex_nw[0] = b - a; ex_wcnt = 3'd1; end
      OP_MUL:   begin ex_nw[0] = prod; ex_wcnt = 3'd1; end
      OP_OVER:  begin ex_nw[0] = b; ex_wcnt = 3'd1; end
      OP_ROT:   begin
        ex_nw[0] = c; ex_nw[1] = a; ex_nw[2] = b; ex_wcnt = 3'd3;
      end
      OP_2SWAP: begin
        ex_nw[0] = c; ex_nw[1] = d; ex_nw[2] = a; ex_nw[3] = b; ex_wcnt = 3'd4;
      end
      OP_2DUP:  begin ex_nw[0] = a; ex_nw[1] = b; ex_wcnt = 3'd2; end
      OP_2OVER: begin ex_nw[0] = c; ex_nw[1] = d; ex_wcnt = 3'd2; end
      OP_DROP:  ex_nw[0] = b;
      OP_2DROP: ex_nw[0] = c;
      OP_LT:    begin ex_nw[0] = DATA_W'($signed(b) < $signed(a)); ex_wcnt = 3'd1; end
      OP_GT:    begin ex_nw[0] = DATA_W'($signed(a) < $signed(b)); ex_wcnt = 3'd1; end
      OP_EQ:    begin ex_nw[0] = DATA_W'(a == b); ex_wcnt = 3'd1; end
      OP_NE:    begin ex_nw[0] = DATA_W'(a != b); ex_wcnt = 3'd1; end
      OP_ZLT:   begin ex_nw[0] = DATA_W'(a[DATA_W-1]); ex_wcnt = 3'd1; end
      OP_ZGT:   begin
        ex_nw[0] = DATA_W'(!a[DATA_W-1] && (a != '0)); ex_wcnt = 3'd1;
      end
      OP_ZEQ:   begin ex_nw[0] = DATA_W'(a == '0); ex_wcnt = 3'd1; end
      default:  ex_nw[0] = a;
    endcase
  end

  // divider step and final signs
  logic [DATA_W:0]   rem_sh, diff;
  logic [DATA_W-1:0] q_fix, r_fix;

  always_comb begin
    rem_sh = {rem, quo[DATA_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    q_fix  = q_neg ? (-quo) : quo;
    r_fix  = r_neg ? (-rem) : rem;
  end

  // memory addressing
  logic [CW-1:0] rd_idx, wr_idx;
  logic          out_free;

  always_comb begin
    rd_idx    = count - CW'(k) - CW'(1);
    wr_idx    = cnt_new - CW'(k) - CW'(1);
    mem_raddr = rd_idx[AW-1:0];
    mem_waddr = wr_idx[AW-1:0];
    mem_wdata = nw[k[1:0]];
    out_free  = !out_valid || !out_stall;
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (k == nread) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts != STS_OK || (is_div && a == '0)) begin
          state_next = ST_DONE;
        end else if (is_div) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_DIV: begin
        if (itc == ($clog2(DATA_W))'(DATA_W - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: state_next = ST_WRITE;
      ST_WRITE: begin
        if (k < wcnt) begin
          mem_we = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      k         <= '0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      pend <= (state == ST_READ) && (k < nread);
      unique case (state)
        ST_IDLE: begin
          k <= '0;
        end
        ST_READ: begin
          if (k < nread) begin
            k <= k + 3'd1;
          end
        end
        ST_EXEC, ST_FIN: begin
          k <= '0;
        end
        ST_WRITE: begin
          if (k < wcnt) begin
            k <= k + 3'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count <= cnt_new;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op    <= in_op;
          opnd  <= in_item.operand;
          sts   <= in_sts;
          nread <= (count > CW'(4)) ? 3'd4 : 3'(count);
          for (int i = 0; i < 4; i++) begin
            win[i] <= '0;
          end
        end
      end
      ST_READ: begin
        if (pend) begin
          win[pidx[1:0]] <= rd_data;
        end
        pidx <= k;
      end
      ST_EXEC: begin
        if (sts != STS_OK || (is_div && a == '0)) begin
          if (sts == STS_OK) begin
            sts <= STS_DIVZ;
          end
          nw[0]   <= a;
          wcnt    <= 3'd0;
          cnt_new <= count;
        end else begin
          for (int i = 0; i < 4; i++) begin
            nw[i] <= ex_nw[i];
          end
          wcnt    <= ex_wcnt;
          cnt_new <= cnt_grow;
        end
        rem   <= '0;
        quo   <= b[DATA_W-1] ? (-b) : b;
        dvs   <= a[DATA_W-1] ? (-a) : a;
        q_neg <= a[DATA_W-1] ^ b[DATA_W-1];
        r_neg <= b[DATA_W-1];
        itc   <= '0;
      end
      ST_DIV: begin
        if (!diff[DATA_W]) begin
          rem <= diff[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        itc <= itc + 1'b1;
      end
      ST_FIN: begin
        case (op) inside
          OP_DIV:    begin nw[0] <= q_fix; wcnt <= 3'd1; end
          OP_MOD:    begin nw[0] <= r_fix; wcnt <= 3'd1; end
          default:   begin nw[0] <= q_fix; nw[1] <= r_fix; wcnt <= 3'd2; end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_item.status <= sts;
          out_item.depth  <= DEPTH_W'(cnt_new);
          if (op == OP_POP && sts == STS_OK) begin
            out_item.value <= a;
          end else if (cnt_new == '0) begin
            out_item.value <= '0;
          end else begin
            out_item.value <= nw[0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/fdsa_checker.sv]
// port-level checker for the forth data stack, bound to the top level
// depends on fdsa_pkg and forth_data_stack_alu_defines.svh
`include "forth_data_stack_alu_defines.svh"

module fdsa_checker
  import fdsa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `FDSA_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `FDSA_AST_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
  `FDSA_AST_NOW(a_divz_depth, out_valid && out_item.status == STS_DIVZ, out_item.depth >= 9'd2)
  `FDSA_AST_NOW(a_under_depth, out_valid && out_item.status == STS_UNDER, out_item.depth < 9'd4)

endmodule

bind forth_data_stack_alu fdsa_checker u_fdsa_checker (.*);
